// ----- rtl/ginv_pkg.sv -----
// ----------------------------------------------------------------------------
// ginv_pkg
// shared widths, register map and sequencer codes for the graph invariant block
// ----------------------------------------------------------------------------
package ginv_pkg;

    localparam int ADJ_W     = 55;
    localparam int VAL_W     = 6;
    localparam int NCOUNT_W  = 4;
    localparam int TYPES_W   = 22;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int MAX_OUT   = 22;
    localparam int OCNT_W    = $clog2(MAX_OUT);

    localparam logic [NCOUNT_W-1:0] NCOUNT_RST = 4'd11;
    localparam logic [TYPES_W-1:0]  TYPES_RST  = '0;

    typedef enum logic {
        REG_NODE_COUNT = 1'b0,
        REG_NODE_TYPES = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROWS  = 4'b0010,
        S_REACH = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        PH_TOTAL = 2'd0,
        PH_DEG   = 2'd1,
        PH_PAIR  = 2'd2
    } phase_t;

endpackage

// ----- rtl/graph_invariant_and_connectivity.sv -----
// ----------------------------------------------------------------------------
// graph_invariant_and_connectivity
// degree-sequence invariant stream and reachability check for small graphs
// ----------------------------------------------------------------------------
//  channel   | ports                               | beat
//  ----------+-------------------------------------+-----------------------------
//  input     | s_valid s_ready s_adjacency         | one graph, packed edge bits
//  result    | m_valid m_ready m_value m_connected | one invariant value
//            | m_last                              | last marks end of stream
//  config    | psel penable pwrite paddr pwdata    | node_count @0, node_types @4
//            | prdata pready                       |
//
//  a graph is accepted from idle, walks its rows in S_ROWS, runs the reachability
//  steps in S_REACH, then sends one result beat per cycle while the output is free:
//  1 + n + g(g+1)/2 beats, where n is the node count and g the number of type groups;
//  the row walk shares one shifter and popcount over the edge bits, row by row
//  aresetn is synchronous; config returns to node_count 11, node_types 0
//  a stalled result beat holds the sequencer; s_ready is high only when idle
// ----------------------------------------------------------------------------
module graph_invariant_and_connectivity
    import ginv_pkg::*;
#(
    parameter int MAX_NODES = 11,
    parameter int TYPE_BITS = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input graph
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ADJ_W-1:0]    s_adjacency,
    // invariant stream
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VAL_W-1:0]    m_value,
    output logic                m_connected,
    output logic                m_last,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int NW   = $clog2(MAX_NODES + 1);
    localparam int IW   = $clog2(MAX_NODES);
    localparam int DW   = $clog2(MAX_NODES);
    localparam int NT   = 1 << TYPE_BITS;
    localparam int GW   = TYPE_BITS + 1;
    localparam int TPAD = MAX_NODES * TYPE_BITS + TYPES_W;

    // config registers
    logic [NCOUNT_W-1:0] node_count_reg;
    logic [TYPES_W-1:0]  node_types_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NCOUNT_RST;
            node_types_reg <= TYPES_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_NODE_COUNT: node_count_reg <= pwdata[NCOUNT_W-1:0];
                REG_NODE_TYPES: node_types_reg <= pwdata[TYPES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_NODE_COUNT: prdata = DATA_W'(node_count_reg);
            REG_NODE_TYPES: prdata = DATA_W'(node_types_reg);
            default:        prdata = '0;
        endcase
    end

    // sequencer state
    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [ADJ_W-1:0]       adj_sh_reg, adj_sh_next;
    logic [TYPE_BITS-1:0]   typ_reg [MAX_NODES];
    logic [TYPE_BITS-1:0]   typ_next [MAX_NODES];
    logic [MAX_NODES-1:0]   nbr_reg [MAX_NODES];
    logic [MAX_NODES-1:0]   nbr_next [MAX_NODES];
    logic [DW-1:0]          deg_reg [MAX_NODES];
    logic [DW-1:0]          deg_next [MAX_NODES];
    logic [VAL_W-1:0]       pair_reg [NT][NT];
    logic [VAL_W-1:0]       pair_next [NT][NT];
    logic [VAL_W-1:0]       total_reg, total_next;
    logic [GW-1:0]          groups_reg, groups_next;
    logic [IW-1:0]          row_reg, row_next;
    logic [MAX_NODES-1:0]   seen_reg, seen_next;
    logic [MAX_NODES-1:0]   left_reg, left_next;
    logic [TYPE_BITS-1:0]   pa_reg, pa_next, pb_reg, pb_next;
    logic [OCNT_W-1:0]      ocnt_reg, ocnt_next;
    logic                   conn_reg, conn_next;

    // result register
    logic                   m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]       m_value_reg, m_value_next;
    logic                   m_connected_reg, m_connected_next;
    logic                   m_last_reg, m_last_next;

    logic [TPAD-1:0]        types_ext;
    logic [MAX_NODES-1:0]   nmask;
    logic [MAX_NODES-1:0]   up_row, full_row, grow;
    logic [MAX_NODES-1:0]   win;
    logic [DW-1:0]          win_deg;
    logic [NW-1:0]          row_len;
    logic [TYPE_BITS-1:0]   tr;
    logic [VAL_W-1:0]       pair_inc [NT][NT];
    logic [DW:0]            up_cnt, full_cnt;
    logic                   out_free, nat_last, is_last;

    assign types_ext = TPAD'(node_types_reg);
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            nmask[j] = (j < int'(n_reg));
        end
    end

    // row walk: the current row's upper edges come off the low end of the shifter
    assign tr       = typ_reg[row_reg];
    assign row_len  = n_reg - NW'(1) - NW'(row_reg);
    assign up_row   = (adj_sh_reg[MAX_NODES-1:0] << (32'(row_reg) + 1)) & nmask;
    assign full_row = nbr_reg[row_reg] | up_row;

    always_comb begin
        up_cnt   = '0;
        full_cnt = '0;
        for (int j = 0; j < MAX_NODES; j++) begin
            up_cnt   = up_cnt + (DW+1)'(up_row[j]);
            full_cnt = full_cnt + (DW+1)'(full_row[j]);
        end
    end

    // per type pair edge increments for the current row
    always_comb begin
        for (int a = 0; a < NT; a++) begin
            for (int b = 0; b < NT; b++) begin
                pair_inc[a][b] = '0;
                for (int j = 0; j < MAX_NODES; j++) begin
                    if (a <= b && up_row[j] &&
                        ((int'(tr) == a && int'(typ_reg[j]) == b) ||
                         (int'(tr) == b && int'(typ_reg[j]) == a))) begin
                        pair_inc[a][b] = pair_inc[a][b] + VAL_W'(1);
                    end
                end
            end
        end
    end

    // one reachability step
    always_comb begin
        grow = seen_reg;
        for (int i = 0; i < MAX_NODES; i++) begin
            if (seen_reg[i]) grow = grow | nbr_reg[i];
        end
        grow = grow & nmask;
    end

    // smallest (type, degree) among nodes not yet sent, lowest node on ties
    always_comb begin
        win_deg = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            win[i] = left_reg[i];
            for (int j = 0; j < MAX_NODES; j++) begin
                if (j != i && left_reg[j]) begin
                    if ({typ_reg[j], deg_reg[j]} < {typ_reg[i], deg_reg[i]} ||
                        ({typ_reg[j], deg_reg[j]} == {typ_reg[i], deg_reg[i]} && j < i)) begin
                        win[i] = 1'b0;
                    end
                end
            end
            if (win[i]) win_deg = win_deg | deg_reg[i];
        end
    end

    assign nat_last = (GW'(pa_reg) == groups_reg - GW'(1)) &&
                      (GW'(pb_reg) == groups_reg - GW'(1));

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        n_next           = n_reg;
        adj_sh_next      = adj_sh_reg;
        typ_next         = typ_reg;
        nbr_next         = nbr_reg;
        deg_next         = deg_reg;
        pair_next        = pair_reg;
        total_next       = total_reg;
        groups_next      = groups_reg;
        row_next         = row_reg;
        seen_next        = seen_reg;
        left_next        = left_reg;
        pa_next          = pa_reg;
        pb_next          = pb_reg;
        ocnt_next        = ocnt_reg;
        conn_next        = conn_reg;
        m_valid_next     = m_valid_reg;
        m_value_next     = m_value_reg;
        m_connected_next = m_connected_reg;
        m_last_next      = m_last_reg;
        is_last          = 1'b0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (node_count_reg == '0) begin
                        n_next = NW'(1);
                    end else if (int'(node_count_reg) > MAX_NODES) begin
                        n_next = NW'(MAX_NODES);
                    end else begin
                        n_next = NW'(node_count_reg);
                    end
                    adj_sh_next = s_adjacency;
                    for (int i = 0; i < MAX_NODES; i++) begin
                        typ_next[i] = types_ext[i*TYPE_BITS +: TYPE_BITS];
                        nbr_next[i] = '0;
                    end
                    for (int a = 0; a < NT; a++) begin
                        for (int b = 0; b < NT; b++) begin
                            pair_next[a][b] = '0;
                        end
                    end
                    total_next  = '0;
                    groups_next = '0;
                    row_next    = '0;
                    state_next  = S_ROWS;
                end
            end
            S_ROWS: begin
                adj_sh_next = adj_sh_reg >> row_len;
                for (int i = 0; i < MAX_NODES; i++) begin
                    for (int j = 0; j < MAX_NODES; j++) begin
                        if ((i == int'(row_reg) && up_row[j]) ||
                            (j == int'(row_reg) && up_row[i])) begin
                            nbr_next[i][j] = 1'b1;
                        end
                    end
                end
                deg_next[row_reg] = full_cnt[DW-1:0];
                total_next = total_reg + VAL_W'(up_cnt);
                if (GW'(tr) + GW'(1) > groups_reg) groups_next = GW'(tr) + GW'(1);
                for (int a = 0; a < NT; a++) begin
                    for (int b = 0; b < NT; b++) begin
                        pair_next[a][b] = pair_reg[a][b] + pair_inc[a][b];
                    end
                end
                if (NW'(row_reg) == n_reg - NW'(1)) begin
                    row_next   = '0;
                    seen_next  = MAX_NODES'(1);
                    state_next = S_REACH;
                end else begin
                    row_next = row_reg + IW'(1);
                end
            end
            S_REACH: begin
                seen_next = grow;
                if (NW'(row_reg) == n_reg - NW'(1)) begin
                    conn_next  = (grow == nmask);
                    left_next  = nmask;
                    phase_next = PH_TOTAL;
                    pa_next    = '0;
                    pb_next    = '0;
                    ocnt_next  = '0;
                    state_next = S_EMIT;
                end else begin
                    row_next = row_reg + IW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    case (phase_reg)
                        PH_TOTAL: begin
                            m_value_next = total_reg;
                            phase_next   = PH_DEG;
                        end
                        PH_DEG: begin
                            m_value_next = VAL_W'(win_deg);
                            left_next    = left_reg & ~win;
                            if ((left_reg & ~win) == '0) phase_next = PH_PAIR;
                        end
                        PH_PAIR: begin
                            m_value_next = pair_reg[pa_reg][pb_reg];
                            is_last      = nat_last;
                            if (GW'(pb_reg) == groups_reg - GW'(1)) begin
                                pa_next = pa_reg + TYPE_BITS'(1);
                                pb_next = pa_reg + TYPE_BITS'(1);
                            end else begin
                                pb_next = pb_reg + TYPE_BITS'(1);
                            end
                        end
                        default: ;
                    endcase
                    if (int'(ocnt_reg) == MAX_OUT - 1) is_last = 1'b1;
                    ocnt_next        = ocnt_reg + OCNT_W'(1);
                    m_valid_next     = 1'b1;
                    m_connected_next = conn_reg;
                    m_last_next      = is_last;
                    if (is_last) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg       <= phase_next;
        n_reg           <= n_next;
        adj_sh_reg      <= adj_sh_next;
        typ_reg         <= typ_next;
        nbr_reg         <= nbr_next;
        deg_reg         <= deg_next;
        pair_reg        <= pair_next;
        total_reg       <= total_next;
        groups_reg      <= groups_next;
        row_reg         <= row_next;
        seen_reg        <= seen_next;
        left_reg        <= left_next;
        pa_reg          <= pa_next;
        pb_reg          <= pb_next;
        ocnt_reg        <= ocnt_next;
        conn_reg        <= conn_next;
        m_value_reg     <= m_value_next;
        m_connected_reg <= m_connected_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_connected = m_connected_reg;
    assign m_last      = m_last_reg;

endmodule
